// File: src/dual_wheel_pi_speed_controller_unit_defines.svh
// Assertion macros for the dual-wheel PI speed controller.
// Included by the top level only; depends on nothing else.
`ifndef DUAL_WHEEL_PI_SPEED_CONTROLLER_UNIT_DEFINES_SVH
`define DUAL_WHEEL_PI_SPEED_CONTROLLER_UNIT_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define DWPSC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// When the first condition holds, the second must hold in the next cycle.
`define DWPSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/dwpsc_pkg.sv
// Shared widths, codes, reset values and interface structs for the
// dual-wheel PI speed controller. No dependencies.
package dwpsc_pkg;

    localparam int ACTION_W   = 2;
    localparam int REF_W      = 10;
    localparam int BIAS_W     = 13;
    localparam int COUNT_W    = 8;
    localparam int DUTY_W     = 8;
    localparam int GAIN_W     = 12;
    localparam int PERIOD_W   = 16;
    localparam int RAW_W      = 16;
    localparam int ERR_W      = 17;
    localparam int ERR_FRAC   = 5;
    localparam int ACC_W      = 64;
    localparam int MUL_W      = 16;
    localparam int MCNT_W     = 5;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Fixed-point alignment of the control law.
    localparam int PROP_SHIFT    = 15;
    localparam int DIV_SHIFT     = 29;
    localparam int INT_CLAMP_EXP = 44;
    localparam int SCALE_BITS    = 5;

    // Output scale 12.5 is applied as 25 followed by one extra bit of shift.
    localparam logic [MUL_W-1:0]  SCALE_FACTOR = MUL_W'(25);
    localparam logic [MCNT_W-1:0] PERIOD_STEPS = MCNT_W'(PERIOD_W);
    localparam logic [MCNT_W-1:0] GAIN_STEPS   = MCNT_W'(GAIN_W);
    localparam logic [MCNT_W-1:0] SCALE_STEPS  = MCNT_W'(SCALE_BITS);

    localparam int DUTY_TOP_DEF       = 250;
    localparam int INTEGRAL_WIDTH_DEF = 40;

    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = GAIN_W'(384);
    localparam logic [GAIN_W-1:0]   INTEGRAL_GAIN_RST = GAIN_W'(512);
    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = PERIOD_W'(655);

    localparam logic [1:0] REG_PROP_GAIN     = 2'd0;
    localparam logic [1:0] REG_INTEGRAL_GAIN = 2'd1;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TACH   = 2'd0,
        ACT_WINDOW = 2'd1,
        ACT_STEP   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count_left;
        logic [COUNT_W-1:0] count_right;
        logic               fresh;
    } tach_state_t;

    typedef struct packed {
        logic                    start;
        logic                    clear;
        logic signed [ACC_W-1:0] mcand;
        logic [MUL_W-1:0]        mplier;
        logic [MCNT_W-1:0]       steps;
    } mac_cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  duty_left;
        logic [DUTY_W-1:0]  duty_right;
        logic [COUNT_W-1:0] count_left;
        logic [COUNT_W-1:0] count_right;
        logic               counts_fresh;
    } pi_result_t;

endpackage

// File: src/dual_wheel_pi_speed_controller_unit.sv
// Tach, window and clear words leave s_tready high; a new word is taken the next cycle.
// A control step holds s_tready low until its result is parked in the output register,
// which raises m_tvalid. Each wheel's products, and the integral update when there is
// one, run through the shared serial MAC that handles one multiplier bit per cycle.
// Asynchronous active-low reset zeroes tallies, counts, flag, integrals and
// raw duties, and loads the gain and period registers with their defaults.
`include "dual_wheel_pi_speed_controller_unit_defines.svh"

module dual_wheel_pi_speed_controller_unit
    import dwpsc_pkg::*;
#(
    parameter int DUTY_TOP       = DUTY_TOP_DEF,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pulse_left[0], pulse_right[1], ref_speed[11:2], steer_bias[24:12], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [ACTION_W-1:0]   s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // duty_left[7:0], duty_right[15:8], count_left[23:16], count_right[31:24]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // counts_fresh[0]
    output logic [0:0]            m_tuser
);

    logic [GAIN_W-1:0]        prop_gain_reg, prop_gain_next;
    logic [GAIN_W-1:0]        integral_gain_reg, integral_gain_next;
    logic [PERIOD_W-1:0]      sample_period_reg, sample_period_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]    out_data_reg, out_data_next;
    logic                     out_fresh_reg, out_fresh_next;

    logic                     cfg_write;
    logic [1:0]               reg_sel;
    logic                     in_take;
    action_t                  action;
    logic                     pulse_left;
    logic                     pulse_right;
    logic [REF_W-1:0]         ref_speed;
    logic signed [BIAS_W-1:0] steer_bias;
    tach_state_t              tach;
    logic                     pi_busy;
    logic                     pi_res_valid;
    logic                     res_ready;
    pi_result_t               pi_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_comb
    begin
        unique case (reg_sel)
            REG_PROP_GAIN:     prdata = APB_DATA_W'(prop_gain_reg);
            REG_INTEGRAL_GAIN: prdata = APB_DATA_W'(integral_gain_reg);
            REG_SAMPLE_PERIOD: prdata = APB_DATA_W'(sample_period_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        prop_gain_next     = prop_gain_reg;
        integral_gain_next = integral_gain_reg;
        sample_period_next = sample_period_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_PROP_GAIN:     prop_gain_next     = pwdata[GAIN_W-1:0];
                REG_INTEGRAL_GAIN: integral_gain_next = pwdata[GAIN_W-1:0];
                REG_SAMPLE_PERIOD: sample_period_next = pwdata[PERIOD_W-1:0];
                default:           prop_gain_next     = prop_gain_reg;
            endcase
        end
    end

    assign action      = action_t'(s_tuser);
    assign pulse_left  = s_tdata[0];
    assign pulse_right = s_tdata[1];
    assign ref_speed   = s_tdata[11:2];
    assign steer_bias  = $signed(s_tdata[24:12]);

    assign s_tready = !pi_busy;
    assign in_take  = s_tvalid && s_tready;

    dwpsc_tach u_tach (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (in_take),
        .action      (action),
        .pulse_left  (pulse_left),
        .pulse_right (pulse_right),
        .tach        (tach)
    );

    dwpsc_pi #(
        .DUTY_TOP       (DUTY_TOP),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_pi (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_take && (action == ACT_STEP)),
        .clear_int     (in_take && (action == ACT_CLEAR)),
        .ref_speed     (ref_speed),
        .steer_bias    (steer_bias),
        .tach          (tach),
        .prop_gain     (prop_gain_reg),
        .integral_gain (integral_gain_reg),
        .sample_period (sample_period_reg),
        .busy          (pi_busy),
        .res_valid     (pi_res_valid),
        .res_ready     (res_ready),
        .result        (pi_result)
    );

    // The output register frees the sequencer as soon as its word is parked.
    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_fresh_next = out_fresh_reg;
        if (pi_res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {pi_result.count_right, pi_result.count_left,
                              pi_result.duty_right, pi_result.duty_left};
            out_fresh_next = pi_result.counts_fresh;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            prop_gain_reg     <= prop_gain_next;
            integral_gain_reg <= integral_gain_next;
            sample_period_reg <= sample_period_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_fresh_reg <= out_fresh_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_fresh_reg;

    `DWPSC_ASSERT_NEXT(a_step_holds_input, clk, rst_n, s_tvalid && s_tready && (s_tuser == ACT_STEP), !s_tready, "control step did not stop input")
    `DWPSC_ASSERT(a_duty_in_range, clk, rst_n, !m_tvalid || (DUTY_TOP > 255) || ((m_tdata[7:0] <= DUTY_TOP) && (m_tdata[15:8] <= DUTY_TOP)), "duty above top")
    `DWPSC_ASSERT_NEXT(a_result_kept, clk, rst_n, pi_res_valid && !res_ready, pi_res_valid, "result dropped while output full")

endmodule

// File: src/dwpsc_tach.sv
// Tachometer pulse tallies, window counts and the fresh flag.
// Depends on dwpsc_pkg.
module dwpsc_tach
    import dwpsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  action_t     action,
    input  logic        pulse_left,
    input  logic        pulse_right,
    output tach_state_t tach
);

    logic [COUNT_W-1:0] left_tally_reg, left_tally_next;
    logic [COUNT_W-1:0] right_tally_reg, right_tally_next;
    logic [COUNT_W-1:0] left_count_reg, left_count_next;
    logic [COUNT_W-1:0] right_count_reg, right_count_next;
    logic               fresh_reg, fresh_next;

    always_comb
    begin
        left_tally_next  = left_tally_reg;
        right_tally_next = right_tally_reg;
        left_count_next  = left_count_reg;
        right_count_next = right_count_reg;
        fresh_next       = fresh_reg;
        if (item_valid)
        begin
            unique case (action)
                ACT_TACH:
                begin
                    // Tallies wrap around at 256.
                    left_tally_next  = left_tally_reg + COUNT_W'(pulse_left);
                    right_tally_next = right_tally_reg + COUNT_W'(pulse_right);
                end
                ACT_WINDOW:
                begin
                    left_count_next  = left_tally_reg;
                    right_count_next = right_tally_reg;
                    left_tally_next  = '0;
                    right_tally_next = '0;
                    fresh_next       = 1'b1;
                end
                ACT_STEP:
                begin
                    fresh_next = 1'b0;
                end
                ACT_CLEAR:
                begin
                    fresh_next = fresh_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_tally_reg  <= '0;
            right_tally_reg <= '0;
            left_count_reg  <= '0;
            right_count_reg <= '0;
            fresh_reg       <= 1'b0;
        end
        else
        begin
            left_tally_reg  <= left_tally_next;
            right_tally_reg <= right_tally_next;
            left_count_reg  <= left_count_next;
            right_count_reg <= right_count_next;
            fresh_reg       <= fresh_next;
        end
    end

    assign tach.count_left  = left_count_reg;
    assign tach.count_right = right_count_reg;
    assign tach.fresh       = fresh_reg;

endmodule

// File: src/dwpsc_mac.sv
// Serial shift-add multiply-accumulate unit: one multiplier bit per cycle.
// Depends on dwpsc_pkg.
module dwpsc_mac
    import dwpsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_cmd_t                cmd,
    output logic                    done,
    output logic signed [ACC_W-1:0] acc
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MCNT_W-1:0]       steps_reg, steps_next;
    logic signed [ACC_W-1:0] mcand_reg, mcand_next;
    logic [MUL_W-1:0]        mplier_reg, mplier_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        steps_next  = steps_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (cmd.start)
        begin
            mcand_next  = cmd.mcand;
            mplier_next = cmd.mplier;
            steps_next  = cmd.steps;
            busy_next   = 1'b1;
            if (cmd.clear)
            begin
                acc_next = '0;
            end
        end
        else if (busy_reg)
        begin
            // The multiplier shifts out at the bottom while the multiplicand
            // moves up one place, so each cycle adds one partial product.
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            steps_next  = steps_reg - MCNT_W'(1);
            if (steps_reg == MCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg  <= steps_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

// File: src/dwpsc_pi.sv
// PI control sequencer for both wheels with anti-windup; drives the shared
// serial MAC. Depends on dwpsc_pkg and dwpsc_mac.
module dwpsc_pi
    import dwpsc_pkg::*;
#(
    parameter int DUTY_TOP       = DUTY_TOP_DEF,
    parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     clear_int,
    input  logic [REF_W-1:0]         ref_speed,
    input  logic signed [BIAS_W-1:0] steer_bias,
    input  tach_state_t              tach,
    input  logic [GAIN_W-1:0]        prop_gain,
    input  logic [GAIN_W-1:0]        integral_gain,
    input  logic [PERIOD_W-1:0]      sample_period,
    output logic                     busy,
    output logic                     res_valid,
    input  logic                     res_ready,
    output pi_result_t               result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WHEEL,
        S_INC,
        S_ISTART,
        S_SUMI,
        S_SUMP,
        S_SCALE,
        S_ROUND,
        S_DONE
    } state_t;

    localparam logic signed [ACC_W-1:0] ACC_ONE    = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] CLAMP_POS  = ACC_ONE <<< INT_CLAMP_EXP;
    localparam logic signed [ACC_W-1:0] CLAMP_NEG  = -CLAMP_POS;
    localparam logic signed [ACC_W-1:0] DIV_ROUND  = (ACC_ONE <<< DIV_SHIFT) - ACC_ONE;
    localparam logic signed [ACC_W-1:0] RAW_MAX    = (ACC_ONE <<< (RAW_W - 1)) - ACC_ONE;
    localparam logic signed [ACC_W-1:0] RAW_MIN    = -RAW_MAX - ACC_ONE;
    localparam logic signed [ACC_W:0]   WIDE_ONE   = (ACC_W + 1)'(1);
    localparam logic signed [ACC_W:0]   INT_HI     =
        (WIDE_ONE <<< (INTEGRAL_WIDTH - 1)) - WIDE_ONE;
    localparam logic signed [ACC_W:0]   INT_LO     = -INT_HI - WIDE_ONE;
    localparam logic signed [RAW_W+1:0] DUTY_TOP_S = (RAW_W + 2)'(DUTY_TOP);
    localparam logic [DUTY_W-1:0]       DUTY_TOP_B = DUTY_W'(DUTY_TOP);

    state_t                           state_reg, state_next;
    logic                             wheel_reg, wheel_next;
    logic signed [ERR_W-1:0]          err_left_reg, err_left_next;
    logic signed [ERR_W-1:0]          err_right_reg, err_right_next;
    logic [COUNT_W-1:0]               cnt_left_reg, cnt_left_next;
    logic [COUNT_W-1:0]               cnt_right_reg, cnt_right_next;
    logic                             fresh_reg, fresh_next;
    logic signed [INTEGRAL_WIDTH-1:0] integ_left_reg, integ_left_next;
    logic signed [INTEGRAL_WIDTH-1:0] integ_right_reg, integ_right_next;
    logic signed [RAW_W-1:0]          raw_left_reg, raw_left_next;
    logic signed [RAW_W-1:0]          raw_right_reg, raw_right_next;

    mac_cmd_t                         mac_cmd;
    logic                             mac_done;
    logic signed [ACC_W-1:0]          mac_acc;

    logic signed [REF_W:0]            diff_left;
    logic signed [REF_W:0]            diff_right;
    logic signed [ERR_W-1:0]          err_left_in;
    logic signed [ERR_W-1:0]          err_right_in;
    logic signed [ERR_W-1:0]          err_cur;
    logic signed [INTEGRAL_WIDTH-1:0] integ_cur;
    logic signed [RAW_W-1:0]          raw_cur;
    logic                             wind;
    logic signed [ACC_W-1:0]          inc;
    logic signed [ACC_W:0]            integ_sum;
    logic signed [INTEGRAL_WIDTH-1:0] integ_new;
    logic signed [ACC_W-1:0]          integ_clamped;
    logic signed [ACC_W-1:0]          rounded;
    logic signed [ACC_W-1:0]          quotient;
    logic signed [RAW_W-1:0]          raw_new;

    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [RAW_W-1:0] raw);
        logic signed [RAW_W+1:0] raw_ext;
        raw_ext = (RAW_W + 2)'(raw);
        if (raw < 0)
        begin
            return '0;
        end
        else if (raw_ext > DUTY_TOP_S)
        begin
            return DUTY_TOP_B;
        end
        return raw[DUTY_W-1:0];
    endfunction

    dwpsc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    // Errors carry five fraction bits: (ref - count) * 32 -/+ bias.
    assign diff_left    = $signed({1'b0, ref_speed}) - $signed({3'b000, tach.count_left});
    assign diff_right   = $signed({1'b0, ref_speed}) - $signed({3'b000, tach.count_right});
    assign err_left_in  = (ERR_W'(diff_left) <<< ERR_FRAC) - ERR_W'(steer_bias);
    assign err_right_in = (ERR_W'(diff_right) <<< ERR_FRAC) + ERR_W'(steer_bias);

    assign err_cur   = wheel_reg ? err_right_reg : err_left_reg;
    assign integ_cur = wheel_reg ? integ_right_reg : integ_left_reg;
    assign raw_cur   = wheel_reg ? raw_right_reg : raw_left_reg;

    // The integral is frozen while the previous raw duty is below 0 or at or above top.
    assign wind = !(((RAW_W + 2)'(raw_cur) >= DUTY_TOP_S) || (raw_cur < 0));

    // Increment is err * period in Q.21, rounded half up to Q.20.
    assign inc       = (mac_acc + ACC_ONE) >>> 1;
    assign integ_sum = (ACC_W + 1)'(integ_cur) + (ACC_W + 1)'(inc);

    always_comb
    begin
        if (integ_sum > INT_HI)
        begin
            integ_new = INT_HI[INTEGRAL_WIDTH-1:0];
        end
        else if (integ_sum < INT_LO)
        begin
            integ_new = INT_LO[INTEGRAL_WIDTH-1:0];
        end
        else
        begin
            integ_new = integ_sum[INTEGRAL_WIDTH-1:0];
        end
    end

    always_comb
    begin
        integ_clamped = ACC_W'(integ_cur);
        if (integ_clamped > CLAMP_POS)
        begin
            integ_clamped = CLAMP_POS;
        end
        else if (integ_clamped < CLAMP_NEG)
        begin
            integ_clamped = CLAMP_NEG;
        end
    end

    // Divide by 2^29 rounding toward zero, then saturate to 16 bits.
    assign rounded  = mac_acc[ACC_W-1] ? (mac_acc + DIV_ROUND) : mac_acc;
    assign quotient = rounded >>> DIV_SHIFT;

    always_comb
    begin
        if (quotient > RAW_MAX)
        begin
            raw_new = RAW_MAX[RAW_W-1:0];
        end
        else if (quotient < RAW_MIN)
        begin
            raw_new = RAW_MIN[RAW_W-1:0];
        end
        else
        begin
            raw_new = quotient[RAW_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        wheel_next       = wheel_reg;
        err_left_next    = err_left_reg;
        err_right_next   = err_right_reg;
        cnt_left_next    = cnt_left_reg;
        cnt_right_next   = cnt_right_reg;
        fresh_next       = fresh_reg;
        integ_left_next  = integ_left_reg;
        integ_right_next = integ_right_reg;
        raw_left_next    = raw_left_reg;
        raw_right_next   = raw_right_reg;
        mac_cmd          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (clear_int)
                begin
                    integ_left_next  = '0;
                    integ_right_next = '0;
                end
                else if (start)
                begin
                    err_left_next  = err_left_in;
                    err_right_next = err_right_in;
                    cnt_left_next  = tach.count_left;
                    cnt_right_next = tach.count_right;
                    fresh_next     = tach.fresh;
                    wheel_next     = 1'b0;
                    state_next     = S_WHEEL;
                end
            end
            S_WHEEL:
            begin
                if (wind)
                begin
                    mac_cmd.start  = 1'b1;
                    mac_cmd.clear  = 1'b1;
                    mac_cmd.mcand  = ACC_W'(err_cur);
                    mac_cmd.mplier = MUL_W'(sample_period);
                    mac_cmd.steps  = PERIOD_STEPS;
                    state_next     = S_INC;
                end
                else
                begin
                    state_next = S_ISTART;
                end
            end
            S_INC:
            begin
                if (mac_done)
                begin
                    if (wheel_reg)
                    begin
                        integ_right_next = integ_new;
                    end
                    else
                    begin
                        integ_left_next = integ_new;
                    end
                    state_next = S_ISTART;
                end
            end
            S_ISTART:
            begin
                mac_cmd.start  = 1'b1;
                mac_cmd.clear  = 1'b1;
                mac_cmd.mcand  = integ_clamped;
                mac_cmd.mplier = MUL_W'(integral_gain);
                mac_cmd.steps  = GAIN_STEPS;
                state_next     = S_SUMI;
            end
            S_SUMI:
            begin
                if (mac_done)
                begin
                    // Proportional term aligned to the Q.28 integral product.
                    mac_cmd.start  = 1'b1;
                    mac_cmd.clear  = 1'b0;
                    mac_cmd.mcand  = ACC_W'(err_cur) <<< PROP_SHIFT;
                    mac_cmd.mplier = MUL_W'(prop_gain);
                    mac_cmd.steps  = GAIN_STEPS;
                    state_next     = S_SUMP;
                end
            end
            S_SUMP:
            begin
                if (mac_done)
                begin
                    mac_cmd.start  = 1'b1;
                    mac_cmd.clear  = 1'b1;
                    mac_cmd.mcand  = mac_acc;
                    mac_cmd.mplier = SCALE_FACTOR;
                    mac_cmd.steps  = SCALE_STEPS;
                    state_next     = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (mac_done)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (wheel_reg)
                begin
                    raw_right_next = raw_new;
                    state_next     = S_DONE;
                end
                else
                begin
                    raw_left_next = raw_new;
                    wheel_next    = 1'b1;
                    state_next    = S_WHEEL;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wheel_reg       <= 1'b0;
            integ_left_reg  <= '0;
            integ_right_reg <= '0;
            raw_left_reg    <= '0;
            raw_right_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            wheel_reg       <= wheel_next;
            integ_left_reg  <= integ_left_next;
            integ_right_reg <= integ_right_next;
            raw_left_reg    <= raw_left_next;
            raw_right_reg   <= raw_right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_left_reg  <= err_left_next;
        err_right_reg <= err_right_next;
        cnt_left_reg  <= cnt_left_next;
        cnt_right_reg <= cnt_right_next;
        fresh_reg     <= fresh_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    assign result.duty_left    = clamp_duty(raw_left_reg);
    assign result.duty_right   = clamp_duty(raw_right_reg);
    assign result.count_left   = cnt_left_reg;
    assign result.count_right  = cnt_right_reg;
    assign result.counts_fresh = fresh_reg;

endmodule
